// File: sv/fit_placement_selector_defines.svh
// ---------------------------------------------------------------------------
// fit_placement_selector_defines
// assertion macros used by the fit placement selector controller
// ---------------------------------------------------------------------------
`ifndef FIT_PLACEMENT_SELECTOR_DEFINES_SVH
`define FIT_PLACEMENT_SELECTOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define FPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fit placement selector: same-cycle check failed");

// condition implies consequence in the next cycle
`define FPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fit placement selector: next-cycle check failed");

`endif

// File: sv/fps_pkg.sv
// ---------------------------------------------------------------------------
// fps_pkg
// types and constants of the fit placement selector
// ---------------------------------------------------------------------------
package fps_pkg;

    localparam int NBLOCKS   = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int CNT_W     = $clog2(NBLOCKS + 1);

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [15:0]          t_field16;
    typedef logic [3:0]           t_field4;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_PLACE  = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_LAST  = 2'd1;
    localparam logic [1:0] MODE_BEST  = 2'd2;

    typedef struct packed {
        logic       op;
        logic       first_block;
        logic [15:0] block_size;
        logic       block_filled;
        logic [15:0] request_size;
        logic [1:0] fit_mode;
    } t_fps_in;

    typedef struct packed {
        logic [15:0] piece_size;
        logic        piece_filled;
        logic        piece_is_request;
        logic [3:0]  block_index;
        logic        no_fit;
        logic        last_piece;
    } t_fps_out;

    // controller to datapath
    typedef struct packed {
        logic wr_en;
        logic load_req;
        logic empty;
        logic rd_en;
        logic rd_scan;
        logic rd_last;
        t_idx rd_addr;
    } t_fps_cmd;

    // datapath to controller
    typedef struct packed {
        logic hold;
        logic last_out;
        t_cnt cnt;
    } t_fps_sts;

endpackage

// File: sv/fps_datapath.sv
// ---------------------------------------------------------------------------
// fps_datapath
// block table memory, fit search registers and piece output register
// ---------------------------------------------------------------------------
module fps_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fps_pkg::t_fps_in  i_in,
    input  fps_pkg::t_fps_cmd i_cmd,
    output fps_pkg::t_fps_sts o_sts,
    output fps_pkg::t_fps_out o_result,
    output logic              o_strobe
);

    fps_pkg::t_size mem_size [fps_pkg::NBLOCKS];
    logic           mem_fill [fps_pkg::NBLOCKS];

    fps_pkg::t_cnt  r_cnt;
    fps_pkg::t_cnt  n_cnt;
    fps_pkg::t_cnt  wr_base;
    logic           wr_ok;

    fps_pkg::t_size r_rd_size;
    logic           r_rd_fill;
    logic           r_dv_scan;
    logic           r_dv_emit;
    logic           r_dlast;
    fps_pkg::t_idx  r_didx;

    fps_pkg::t_size r_req;
    logic [1:0]     r_mode;
    logic           r_found;
    fps_pkg::t_idx  r_chosen;
    fps_pkg::t_size r_best;
    logic           r_rem_phase;

    fps_pkg::t_fps_out r_out;
    logic              r_out_vld;
    fps_pkg::t_fps_out n_out;

    logic           fits;
    logic           take;
    fps_pkg::t_size left;
    logic           is_chosen;
    logic           hold;

    // append: a first block restarts the table at entry zero
    always_comb begin
        wr_base = i_in.first_block ? '0 : r_cnt;
        wr_ok   = i_cmd.wr_en && (wr_base < fps_pkg::t_cnt'(fps_pkg::NBLOCKS));
        n_cnt   = r_cnt;
        if (wr_ok) begin
            n_cnt = fps_pkg::t_cnt'(wr_base + fps_pkg::t_cnt'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem_size[wr_base[fps_pkg::IDX_W-1:0]] <= fps_pkg::t_size'(i_in.block_size);
            mem_fill[wr_base[fps_pkg::IDX_W-1:0]] <= i_in.block_filled;
        end
        if (i_cmd.rd_en) begin
            r_rd_size <= mem_size[i_cmd.rd_addr];
            r_rd_fill <= mem_fill[i_cmd.rd_addr];
        end
    end

    // second piece of a split block keeps the read beat in place
    assign is_chosen = r_found && (r_didx == r_chosen);
    assign hold      = r_dv_emit && is_chosen && !r_rem_phase && (r_rd_size != r_req);
    assign left      = r_rd_size - r_req;
    assign fits      = !r_rd_fill && (r_req <= r_rd_size);

    always_comb begin
        take = 1'b0;
        if (r_dv_scan && fits) begin
            case (r_mode)
                fps_pkg::MODE_FIRST: take = !r_found;
                fps_pkg::MODE_LAST:  take = 1'b1;
                default:             take = !r_found || (left < r_best);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_scan   <= 1'b0;
            r_dv_emit   <= 1'b0;
            r_rem_phase <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (!hold) begin
                r_dv_scan <= i_cmd.rd_en && i_cmd.rd_scan;
                r_dv_emit <= i_cmd.rd_en && !i_cmd.rd_scan;
            end
            if (hold) begin
                r_rem_phase <= 1'b1;
            end else if (r_dv_emit) begin
                r_rem_phase <= 1'b0;
            end
            if (i_cmd.load_req) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold && i_cmd.rd_en) begin
            r_didx  <= i_cmd.rd_addr;
            r_dlast <= i_cmd.rd_last;
        end
        if (i_cmd.load_req) begin
            r_req  <= fps_pkg::t_size'(i_in.request_size);
            r_mode <= i_in.fit_mode;
        end
        if (take) begin
            r_chosen <= r_didx;
            r_best   <= left;
        end
    end

    always_comb begin
        n_out = '0;
        if (i_cmd.empty) begin
            n_out.no_fit     = 1'b1;
            n_out.last_piece = 1'b1;
        end else begin
            n_out.block_index = fps_pkg::t_field4'(r_didx);
            n_out.last_piece  = r_dlast && !hold;
            if (is_chosen && !r_rem_phase) begin
                n_out.piece_size       = fps_pkg::t_field16'(r_req);
                n_out.piece_is_request = 1'b1;
            end else if (is_chosen) begin
                n_out.piece_size = fps_pkg::t_field16'(left);
            end else if (r_rd_fill) begin
                n_out.piece_filled = 1'b1;
                n_out.no_fit       = !r_found;
            end else begin
                n_out.piece_size = fps_pkg::t_field16'(r_rd_size);
                n_out.no_fit     = !r_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_dv_emit || i_cmd.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv_emit || i_cmd.empty) begin
            r_out <= n_out;
        end
    end

    assign o_sts.hold     = hold;
    assign o_sts.last_out = r_dv_emit && r_dlast && !hold;
    assign o_sts.cnt      = r_cnt;
    assign o_result       = r_out;
    assign o_strobe       = r_out_vld;

endmodule

// File: sv/fps_ctrl.sv
// ---------------------------------------------------------------------------
// fps_ctrl
// sequencer for append, fit scan and piece listing
// ---------------------------------------------------------------------------
`include "fit_placement_selector_defines.svh"

module fps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  fps_pkg::t_fps_sts i_sts,
    output fps_pkg::t_fps_cmd o_cmd,
    output logic              o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_DRAIN
    } t_state;

    t_state        r_state;
    t_state        n_state;
    fps_pkg::t_idx r_addr;
    fps_pkg::t_idx n_addr;
    logic          at_last;

    assign at_last = fps_pkg::t_cnt'(fps_pkg::t_cnt'(r_addr) + fps_pkg::t_cnt'(1)) == i_sts.cnt;

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        o_cmd         = '0;
        o_cmd.rd_addr = r_addr;
        o_cmd.rd_last = at_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == fps_pkg::OP_APPEND) begin
                        o_cmd.wr_en = 1'b1;
                    end else if (i_sts.cnt == '0) begin
                        o_cmd.empty = 1'b1;
                    end else begin
                        o_cmd.load_req = 1'b1;
                        n_state        = S_SCAN;
                        n_addr         = '0;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_scan = 1'b1;
                if (at_last) begin
                    n_state = S_EMIT;
                    n_addr  = '0;
                end else begin
                    n_addr = fps_pkg::t_idx'(r_addr + fps_pkg::t_idx'(1));
                end
            end
            S_EMIT: begin
                if (!i_sts.hold) begin
                    o_cmd.rd_en = 1'b1;
                    if (at_last) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_addr = fps_pkg::t_idx'(r_addr + fps_pkg::t_idx'(1));
                    end
                end
            end
            S_DRAIN: begin
                if (i_sts.last_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    `FPS_ASSERT_SAME(a_hold_in_listing, i_sts.hold, (r_state == S_EMIT) || (r_state == S_DRAIN))
    `FPS_ASSERT_SAME(a_no_read_on_hold, i_sts.hold, !o_cmd.rd_en)
    `FPS_ASSERT_SAME(a_last_in_drain, i_sts.last_out, r_state == S_DRAIN)
    `FPS_ASSERT_NEXT(a_idle_after_last, i_sts.last_out, r_state == S_IDLE)

endmodule

// File: sv/fit_placement_selector.sv
// ---------------------------------------------------------------------------
// fit_placement_selector
// first, last and best fit placement over a table of memory blocks
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An append gives no
// result. A place keeps busy high while the single read port of the block
// table is walked once for the fit search and once for the listing, one entry
// per cycle except while the second piece of a split block holds the listing.
// Pieces appear on o_result with o_strobe high for one cycle each, in table
// order, and cannot be held off, so the receiver must take every strobed beat.
// A place on an empty table gives one piece the cycle after it is taken.
module fit_placement_selector (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fps_pkg::t_fps_in  i_in,
    output fps_pkg::t_fps_out o_result,
    output logic              o_strobe
);

    fps_pkg::t_fps_cmd cmd;
    fps_pkg::t_fps_sts sts;

    fps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_in.op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    fps_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

// File: tb/fit_placement_selector_tb.sv
// ---------------------------------------------------------------------------
// fit_placement_selector_tb
// self-checking bench: loads block tables through append beats, issues first,
// last and best fit placements, and checks every listed piece against a
// behavioral copy of the table kept in the bench
// ---------------------------------------------------------------------------
module fit_placement_selector_tb;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          RANDOM_ITEMS  = 240;
    localparam logic [1:0]  MODE_SPARE    = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    fps_pkg::t_fps_in  i_in;
    fps_pkg::t_fps_out o_result;
    logic              o_strobe;

    // bench copy of the block table
    logic [15:0] tbl_size [fps_pkg::NBLOCKS];
    logic        tbl_filled [fps_pkg::NBLOCKS];
    int          tbl_count;

    fps_pkg::t_fps_out pieces_due [$];
    fps_pkg::t_fps_out due_piece;

    int burst_left;
    int items_sent;
    int fail_count;
    int cycle_count;

    fit_placement_selector dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic fps_pkg::t_fps_out make_piece(input logic [15:0] size,
                                                     input logic filled,
                                                     input logic is_req, input int idx,
                                                     input logic nofit);
        fps_pkg::t_fps_out p;
        p.piece_size       = size;
        p.piece_filled     = filled;
        p.piece_is_request = is_req;
        p.block_index      = idx[3:0];
        p.no_fit           = nofit;
        p.last_piece       = 1'b0;
        return p;
    endfunction

    // updates the table copy; for a place, queues the listing it should produce.
    // returns 0 for an append dropped on a full table
    function automatic bit predict_item(input fps_pkg::t_fps_in item);
        fps_pkg::t_fps_out listing [$];
        fps_pkg::t_fps_out tail;
        logic [15:0]       left;
        logic [15:0]       best;
        bit                found;
        int                chosen;
        if (item.op == fps_pkg::OP_APPEND) begin
            if (item.first_block)
                tbl_count = 0;
            if (tbl_count >= fps_pkg::NBLOCKS)
                return 1'b0;
            tbl_size[tbl_count]   = item.block_size;
            tbl_filled[tbl_count] = item.block_filled;
            tbl_count++;
            return 1'b1;
        end
        found  = 1'b0;
        chosen = 0;
        best   = '0;
        if (tbl_count == 0)
            listing.push_back(make_piece(16'd0, 1'b0, 1'b0, 0, 1'b1));
        for (int i = 0; i < tbl_count; i++) begin
            if (!tbl_filled[i] && item.request_size <= tbl_size[i]) begin
                left = tbl_size[i] - item.request_size;
                case (item.fit_mode)
                    fps_pkg::MODE_FIRST: begin
                        if (!found) begin
                            found  = 1'b1;
                            chosen = i;
                        end
                    end
                    fps_pkg::MODE_LAST: begin
                        found  = 1'b1;
                        chosen = i;
                    end
                    default: begin
                        // best fit, ties keep the lower index
                        if (!found || left < best) begin
                            found  = 1'b1;
                            best   = left;
                            chosen = i;
                        end
                    end
                endcase
            end
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (found && i == chosen) begin
                left = tbl_size[i] - item.request_size;
                listing.push_back(make_piece(item.request_size, 1'b0, 1'b1, i, 1'b0));
                if (left != 16'd0)
                    listing.push_back(make_piece(left, 1'b0, 1'b0, i, 1'b0));
            end else if (tbl_filled[i]) begin
                listing.push_back(make_piece(16'd0, 1'b1, 1'b0, i, !found));
            end else begin
                listing.push_back(make_piece(tbl_size[i], 1'b0, 1'b0, i, !found));
            end
        end
        tail = listing.pop_back();
        tail.last_piece = 1'b1;
        listing.push_back(tail);
        foreach (listing[k])
            pieces_due.push_back(listing[k]);
        return 1'b1;
    endfunction

    function automatic fps_pkg::t_fps_in make_append(input logic first,
                                                     input logic [15:0] size,
                                                     input logic filled);
        fps_pkg::t_fps_in item;
        item.op           = fps_pkg::OP_APPEND;
        item.first_block  = first;
        item.block_size   = size;
        item.block_filled = filled;
        item.request_size = 16'($urandom);
        item.fit_mode     = 2'($urandom_range(0, 3));
        return item;
    endfunction

    function automatic fps_pkg::t_fps_in make_place(input logic first,
                                                    input logic [15:0] req,
                                                    input logic [1:0] mode);
        fps_pkg::t_fps_in item;
        item.op           = fps_pkg::OP_PLACE;
        item.first_block  = first;
        item.block_size   = 16'($urandom);
        item.block_filled = 1'($urandom_range(0, 1));
        item.request_size = req;
        item.fit_mode     = mode;
        return item;
    endfunction

    function automatic logic [15:0] rand_size();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(1, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    // requests near a stored size hit exact fits, splits and near misses
    function automatic logic [15:0] pick_request();
        logic [15:0] probe_size;
        if (tbl_count == 0)
            return rand_size();
        probe_size = tbl_size[$urandom_range(0, tbl_count - 1)];
        case ($urandom_range(0, 6))
            0:       return probe_size;
            1:       return probe_size - 16'd1;
            2:       return probe_size + 16'd1;
            3:       return 16'd0;
            default: return rand_size();
        endcase
    endfunction

    task automatic send_item(input fps_pkg::t_fps_in item);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        i_in  <= item;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (predict_item(item))
            items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pieces_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input fps_pkg::t_fps_out exp_p,
                                 input fps_pkg::t_fps_out got_p);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s: expected size %0d filled %0b req %0b idx %0d no_fit %0b last %0b",
                     what, exp_p.piece_size, exp_p.piece_filled, exp_p.piece_is_request,
                     exp_p.block_index, exp_p.no_fit, exp_p.last_piece);
            $display("%s: got      size %0d filled %0b req %0b idx %0d no_fit %0b last %0b",
                     what, got_p.piece_size, got_p.piece_filled, got_p.piece_is_request,
                     got_p.block_index, got_p.no_fit, got_p.last_piece);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pieces_due.size() == 0) begin
                note_mismatch("unexpected piece", '0, o_result);
            end else begin
                due_piece = pieces_due.pop_front();
                if (o_result.piece_size !== due_piece.piece_size
                    || o_result.piece_filled !== due_piece.piece_filled
                    || o_result.piece_is_request !== due_piece.piece_is_request
                    || o_result.block_index !== due_piece.block_index
                    || o_result.no_fit !== due_piece.no_fit
                    || o_result.last_piece !== due_piece.last_piece)
                    note_mismatch("piece mismatch", due_piece, o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fit_placement_selector test failed");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_item(make_place(1'b0, 16'd0, fps_pkg::MODE_FIRST));
    endtask

    task automatic test_table_full();
        send_item(make_append(1'b1, 16'd1000, 1'b0));
        for (int k = 1; k < fps_pkg::NBLOCKS; k++)
            send_item(make_append(1'b0, (k % 3 == 0) ? 16'hFFFF : 16'(k * 37), k % 3 == 0));
        // table is full, this one is dropped
        send_item(make_append(1'b0, 16'd7, 1'b0));
        // nothing free is big enough, whole table listed with no_fit
        send_item(make_place(1'b1, 16'hFFFF, fps_pkg::MODE_LAST));
    endtask

    task automatic test_fit_modes();
        // clear on a full table still stores
        send_item(make_append(1'b1, 16'd10, 1'b0));
        send_item(make_append(1'b0, 16'hFFFF, 1'b1));
        send_item(make_append(1'b0, 16'd5, 1'b0));
        send_item(make_append(1'b0, 16'd0, 1'b0));
        send_item(make_append(1'b0, 16'hFFFF, 1'b0));
        send_item(make_place(1'b0, 16'd1, fps_pkg::MODE_FIRST));
        send_item(make_place(1'b0, 16'd10, fps_pkg::MODE_LAST));
        // zero request lands exactly on the zero-sized block
        send_item(make_place(1'b0, 16'd0, fps_pkg::MODE_BEST));
        send_item(make_place(1'b1, 16'd4, MODE_SPARE));
        wait_drained();
    endtask

    task automatic test_random();
        int goal;
        int rows;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            if ($urandom_range(0, 9) < 8) begin
                rows = $urandom_range(1, 18);
                for (int k = 0; k < rows; k++)
                    send_item(make_append(k == 0, rand_size(), $urandom_range(0, 3) == 0));
                repeat ($urandom_range(1, 4))
                    send_item(make_place(1'($urandom_range(0, 1)), pick_request(),
                                         2'($urandom_range(0, 3))));
            end else if ($urandom_range(0, 1) == 0) begin
                send_item(make_append(1'($urandom_range(0, 1)), 16'($urandom),
                                      1'($urandom_range(0, 1))));
            end else begin
                send_item(make_place(1'($urandom_range(0, 1)), 16'($urandom),
                                     2'($urandom_range(0, 3))));
            end
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        tbl_count   = 0;
        burst_left  = 0;
        items_sent  = 0;
        fail_count  = 0;
        cycle_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_table_full();
        test_fit_modes();
        test_random();
        wait_drained();

        if (fail_count == 0 && pieces_due.size() == 0) begin
            $display("fit_placement_selector test passed");
        end else begin
            $display("fit_placement_selector test failed");
        end
        $finish;
    end

endmodule
